// ----- hw/rtl/rgb_triple_text_parser_defines.svh -----
// assertion helpers for the rgb triple text parser
`ifndef RGB_TRIPLE_TEXT_PARSER_DEFINES_SVH
`define RGB_TRIPLE_TEXT_PARSER_DEFINES_SVH

// condition and consequence in the same cycle
`define RTTP_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define RTTP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rttp_pkg.sv -----
package rttp_pkg;

    // scan phase of the number reader
    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_DONE   = 3'd3,
        PH_FAIL   = 3'd4
    } rttp_phase_t;

    // status codes on the result beat
    localparam logic STATUS_CHANGED = 1'b0;
    localparam logic STATUS_BAD     = 1'b1;

    // ascii codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // magnitude saturation point and clamp value
    localparam logic [8:0]  MAG_SAT   = 9'd256;
    localparam logic [12:0] MAG_SAT_W = 13'd256;
    localparam logic [7:0]  VAL_MAX   = 8'd255;
    localparam logic [1:0]  NUM_COUNT = 2'd3;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // finished number value: negatives give zero, large values clamp
    function automatic logic [7:0] clamp_value(input logic neg, input logic [8:0] mag);
        logic [7:0] v;
        if (neg)
            v = 8'd0;
        else if (mag[8])
            v = VAL_MAX;
        else
            v = mag[7:0];
        return v;
    endfunction

endpackage

// ----- hw/rtl/rgb_triple_text_parser.sv -----
// rgb triple text parser
// The slave stream carries a text payload one byte per beat: tdata holds the
// byte, tlast marks the final byte, tuser flags a request with no payload
// (that beat alone ends the request and its byte is ignored). Three decimal
// numbers are read with strtol rules (blanks skipped, optional sign), each
// clamped to 0..255. At the end of a request one result beat leaves on the
// master stream: tdata holds the stored red, green and blue, tuser the status
// (0 changed, 1 bad request). A request without three numbers keeps the
// stored colour and reports bad request.
// A beat is taken into an input register and handled from there; a beat that
// ends a request loads its result into the result register.
// Throughput: one byte per cycle, except that a beat ending a request waits
// while the result register is full; the state update lies between the two.
// Reset clears the parser, the stored colour (to black) and both registers.
// When the receiver stalls, bytes that end no request keep flowing; a beat
// that ends a request waits in the input register, with tready held low,
// until the result register is free.
`include "rgb_triple_text_parser_defines.svh"

module rgb_triple_text_parser
    import rttp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] empty_payload
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_axis_tuser    // [0] status
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // parser state
    rttp_phase_t phase_reg, phase_next;
    logic [1:0]  index_reg, index_next;
    logic        neg_reg, neg_next;
    logic [8:0]  mag_reg, mag_next;
    logic [7:0]  pend_reg [3];
    logic [7:0]  pend_next [3];
    logic [7:0]  colour_reg [3];
    logic [7:0]  colour_next [3];
    logic        status_next;

    // result register
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        out_status_reg;

    logic ends_request;
    logic advance;
    logic out_load;
    logic out_free;

    // handshake
    assign ends_request  = in_last_reg || in_empty_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!ends_request || out_free);
    assign out_load      = advance && ends_request;
    assign s_axis_tready = !in_valid_reg || advance;

    // input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
    end

    // next parser state for the byte in the input register
    always_comb
    begin
        logic        do_fin;
        logic        do_scan;
        logic [7:0]  c;
        logic [3:0]  d;
        logic [12:0] m;
        logic [7:0]  v;

        c = in_byte_reg;
        d = 4'(c - CH_ZERO);
        m = 13'({mag_reg, 3'b000}) + 13'({mag_reg, 1'b0}) + 13'(d);
        v = 8'd0;
        do_fin  = 1'b0;
        do_scan = 1'b0;

        phase_next = phase_reg;
        index_next = index_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        for (int i = 0; i < 3; i++)
        begin
            pend_next[i]   = pend_reg[i];
            colour_next[i] = colour_reg[i];
        end
        status_next = STATUS_BAD;

        if (in_empty_reg)
        begin
            phase_next = PH_SKIP;
            index_next = 2'd0;
            neg_next   = 1'b0;
            mag_next   = 9'd0;
        end
        else
        begin
            // byte step
            unique case (phase_reg)
                PH_SKIP:
                begin
                    do_scan = 1'b1;
                end
                PH_SIGN:
                begin
                    if (is_digit(c))
                    begin
                        mag_next   = 9'(d);
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit(c))
                        mag_next = (m > MAG_SAT_W) ? MAG_SAT : m[8:0];
                    else
                        do_fin = 1'b1;
                end
                default:
                begin
                end
            endcase

            // number ended by a non-digit
            if (do_fin)
            begin
                v = clamp_value(neg_next, mag_next);
                case (index_next)
                    2'd0:    pend_next[0] = v;
                    2'd1:    pend_next[1] = v;
                    2'd2:    pend_next[2] = v;
                    default: ;
                endcase
                index_next = index_next + 2'd1;
                neg_next   = 1'b0;
                mag_next   = 9'd0;
                phase_next = (index_next == NUM_COUNT) ? PH_DONE : PH_SKIP;
                do_scan    = (phase_next == PH_SKIP);
            end

            // start of a new scan
            if (do_scan)
            begin
                if (is_blank(c))
                begin
                end
                else if ((c == CH_PLUS) || (c == CH_MINUS))
                begin
                    neg_next   = (c == CH_MINUS);
                    phase_next = PH_SIGN;
                end
                else if (is_digit(c))
                begin
                    mag_next   = 9'(d);
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_FAIL;
                end
            end

            // end of payload terminates the request
            if (in_last_reg)
            begin
                if (phase_next == PH_DIGITS)
                begin
                    v = clamp_value(neg_next, mag_next);
                    case (index_next)
                        2'd0:    pend_next[0] = v;
                        2'd1:    pend_next[1] = v;
                        2'd2:    pend_next[2] = v;
                        default: ;
                    endcase
                    index_next = index_next + 2'd1;
                    phase_next = (index_next == NUM_COUNT) ? PH_DONE : PH_SKIP;
                end
                if (phase_next == PH_DONE)
                begin
                    for (int i = 0; i < 3; i++)
                        colour_next[i] = pend_next[i];
                    status_next = STATUS_CHANGED;
                end
                phase_next = PH_SKIP;
                index_next = 2'd0;
                neg_next   = 1'b0;
                mag_next   = 9'd0;
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            index_reg <= 2'd0;
            neg_reg   <= 1'b0;
            mag_reg   <= 9'd0;
            for (int i = 0; i < 3; i++)
                colour_reg[i] <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            for (int i = 0; i < 3; i++)
                colour_reg[i] <= colour_next[i];
        end
    end

    // pending values, written before they are read in a request
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
                pend_reg[i] <= pend_next[i];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg   <= {colour_next[2], colour_next[1], colour_next[0]};
            out_status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // checks
    `RTTP_ASSERT_SAME(a_done_index, 1'b1, ((index_reg == NUM_COUNT) == (phase_reg == PH_DONE)), "number index and done phase disagree")
    `RTTP_ASSERT_SAME(a_mag_range, 1'b1, (mag_reg <= MAG_SAT), "magnitude above saturation")
    `RTTP_ASSERT_SAME(a_neg_phase, neg_reg, ((phase_reg == PH_SIGN) || (phase_reg == PH_DIGITS) || (phase_reg == PH_FAIL)), "sign flag set outside a number")
    `RTTP_ASSERT_NEXT(a_result_load, out_load, (out_valid_reg && (index_reg == 2'd0) && (phase_reg == PH_SKIP)), "request end did not restart parser")

endmodule

// ----- sim/rgb_triple_text_parser_tb.sv -----
`default_nettype none

module rgb_triple_text_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rttp_pkg::*;

    // one result beat: status and the stored colour
    typedef struct packed {
        logic       status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] payload_byte
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;     // [0] empty_payload
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [7:0] red, [15:8] green, [23:16] blue
    logic        m_axis_tuser;            // [0] status

    // predicted parser state
    rttp_phase_t scan_ph;
    logic [1:0]  num_idx;
    logic        neg_q;
    logic [8:0]  mag_q;
    logic [7:0]  pend_rgb [0:2];
    logic [7:0]  colour_rgb [0:2];

    colour_beat_t colour_results_q [$];
    logic [7:0]   req_bytes [$];

    int  beats_sent = 0;
    int  requests_sent = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  changed_seen = 0;
    int  bad_seen = 0;
    int  rx_hold = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_stalls = 1'b1;

    rgb_triple_text_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // colour predictor
    // ------------------------------------------------------------------

    task automatic parser_clear();
        scan_ph = PH_SKIP;
        num_idx = 2'd0;
        neg_q   = 1'b0;
        mag_q   = 9'd0;
    endtask

    // a number in progress is closed: negatives read as zero, big ones clamp
    task automatic close_number();
        if (neg_q)
            pend_rgb[num_idx] = 8'd0;
        else if (mag_q > 9'd255)
            pend_rgb[num_idx] = 8'd255;
        else
            pend_rgb[num_idx] = mag_q[7:0];
        num_idx = num_idx + 2'd1;
        neg_q   = 1'b0;
        mag_q   = 9'd0;
        scan_ph = (num_idx == NUM_COUNT) ? PH_DONE : PH_SKIP;
    endtask

    // first non-blank byte of a number
    task automatic open_number(input logic [7:0] c);
        if (c inside {8'h20, [8'h09:8'h0D]}) begin
            scan_ph = PH_SKIP;
        end
        else if (c == CH_PLUS || c == CH_MINUS) begin
            neg_q   = (c == CH_MINUS);
            scan_ph = PH_SIGN;
        end
        else if (c inside {[8'h30:8'h39]}) begin
            mag_q   = {1'b0, c - CH_ZERO};
            scan_ph = PH_DIGITS;
        end
        else begin
            scan_ph = PH_FAIL;
        end
    endtask

    task automatic predict_beat(input logic [7:0] c, input logic lst, input logic emp);
        int           acc;
        colour_beat_t res;
        if (emp) begin
            parser_clear();
            res = '{STATUS_BAD, colour_rgb[0], colour_rgb[1], colour_rgb[2]};
            colour_results_q.push_back(res);
            return;
        end
        case (scan_ph)
            PH_SKIP: open_number(c);
            PH_SIGN: begin
                if (c inside {[8'h30:8'h39]}) begin
                    mag_q   = {1'b0, c - CH_ZERO};
                    scan_ph = PH_DIGITS;
                end
                else begin
                    scan_ph = PH_FAIL;
                end
            end
            PH_DIGITS: begin
                if (c inside {[8'h30:8'h39]}) begin
                    acc   = int'(mag_q) * 10 + int'(c - CH_ZERO);
                    mag_q = (acc > 256) ? 9'd256 : acc[8:0];
                end
                else begin
                    close_number();
                    if (scan_ph == PH_SKIP)
                        open_number(c);
                end
            end
            default: ;
        endcase
        if (!lst)
            return;
        // end of payload terminates a number still being read
        if (scan_ph == PH_DIGITS)
            close_number();
        if (scan_ph == PH_DONE) begin
            colour_rgb = pend_rgb;
            res.status = STATUS_CHANGED;
        end
        else begin
            res.status = STATUS_BAD;
        end
        res.red   = colour_rgb[0];
        res.green = colour_rgb[1];
        res.blue  = colour_rgb[2];
        parser_clear();
        colour_results_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // result checker and input monitor
    // ------------------------------------------------------------------

    always @(posedge clk) begin : check_and_predict
        colour_beat_t got;
        colour_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
            results_seen++;
            if (colour_results_q.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result beat with nothing expected: st=%0d rgb=%0d,%0d,%0d",
                             $realtime, got.status, got.red, got.green, got.blue);
                mismatches++;
            end
            else begin
                want = colour_results_q.pop_front();
                if (want.status == STATUS_CHANGED)
                    changed_seen++;
                else
                    bad_seen++;
                if (got.status != want.status || got.red != want.red ||
                    got.green != want.green || got.blue != want.blue) begin
                    if (mismatches < 10)
                        $display("%0t: result %0d: exp st=%0d rgb=%0d,%0d,%0d got st=%0d rgb=%0d,%0d,%0d",
                                 $realtime, results_seen, want.status, want.red, want.green,
                                 want.blue, got.status, got.red, got.green, got.blue);
                    mismatches++;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_beat(s_axis_tdata, s_axis_tlast, s_axis_tuser);
    end

    // receiver back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int idle_cycles();
        int r;
        if (!sender_idles)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] blank_char();
        if ($urandom_range(0, 1) == 0)
            return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    // one beat on the slave side, waits for the handshake
    task automatic send_beat(input logic [7:0] b, input logic lst, input logic emp);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        s_axis_tuser  <= emp;
        do @(posedge clk); while (!s_axis_tready);
        beats_sent++;
        if (lst || emp)
            requests_sent++;
    endtask

    // the bytes in req_bytes as one payload, last flag on the final byte; an empty request if there are none
    task automatic send_request();
        if (req_bytes.size() == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        for (int i = 0; i < req_bytes.size(); i++)
            send_beat(req_bytes[i], i == req_bytes.size() - 1, 1'b0);
    endtask

    task automatic send_text(input string txt);
        req_bytes.delete();
        for (int i = 0; i < txt.len(); i++)
            req_bytes.push_back(txt[i]);
        send_request();
    endtask

    // sender holds off until every outstanding result has left
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (results_seen < requests_sent)
            @(posedge clk);
    endtask

    // one to three numbers, mostly three, with random padding, signs, lengths and trailing junk
    task automatic build_triple();
        int n_num;
        int n_dig;
        int n_pad;
        int r;
        req_bytes.delete();
        n_num = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 3;
        for (int k = 0; k < n_num; k++) begin
            if (k == 0)
                n_pad = $urandom_range(0, 2);
            else
                n_pad = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            repeat (n_pad) req_bytes.push_back(blank_char());
            if ($urandom_range(0, 3) == 0)
                req_bytes.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            r = $urandom_range(0, 99);
            if (r < 4)
                n_dig = 0;
            else if (r < 15)
                n_dig = $urandom_range(4, 7);
            else
                n_dig = $urandom_range(1, 3);
            repeat (n_dig) req_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) req_bytes.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 4) == 0)
            req_bytes.push_back(blank_char());
        if (req_bytes.size() == 0)
            req_bytes.push_back(blank_char());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // request with no payload right after reset, byte and tlast ignored
    task automatic test_empty_request();
        send_beat(8'hFF, 1'b1, 1'b1);
    endtask

    // minus zero, plus sign ending a number, tab separator, saturation
    task automatic test_sign_and_clamp();
        send_text("-0+9\t999");
    endtask

    // sign without digits, missing number, stray byte, empty mid-payload
    task automatic test_malformed();
        send_text("+ 1");
        send_text("7 8");
        req_bytes = '{8'h80};
        send_request();
        send_beat(8'h34, 1'b0, 1'b0);
        send_beat(CH_SPACE, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    // bytes after the third number do not matter
    task automatic test_trailing_bytes();
        send_text("1 2 3x");
    endtask

    // sender waits for each result before the next request
    task automatic test_drain_between_requests();
        repeat (6) begin
            build_triple();
            send_request();
            wait_results();
        end
    endtask

    task automatic test_random_requests(input int n_beats, input bit idles, input bit stalls);
        int stop_at;
        stop_at         = beats_sent + n_beats;
        sender_idles    = idles;
        receiver_stalls = stalls;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 29) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            else begin
                build_triple();
                send_request();
            end
        end
    endtask

    // random bytes, corrupted triples and requests cut short by an empty beat
    task automatic test_noise(input int n_beats);
        int stop_at;
        int sel;
        int n_keep;
        stop_at         = beats_sent + n_beats;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        while (beats_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                req_bytes.delete();
                repeat ($urandom_range(1, 6)) req_bytes.push_back(8'($urandom_range(0, 255)));
                send_request();
            end
            else if (sel < 75) begin
                build_triple();
                req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
                send_request();
            end
            else if (sel < 90) begin
                build_triple();
                n_keep = $urandom_range(0, req_bytes.size() - 1);
                for (int i = 0; i < n_keep; i++)
                    send_beat(req_bytes[i], 1'b0, 1'b0);
                send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
            else begin
                send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        parser_clear();
        pend_rgb   = '{8'd0, 8'd0, 8'd0};
        colour_rgb = '{8'd0, 8'd0, 8'd0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_request();
        test_sign_and_clamp();
        test_malformed();
        test_trailing_bytes();
        test_drain_between_requests();
        test_random_requests(400, 1'b1, 1'b1);
        test_random_requests(300, 1'b0, 1'b0);
        test_random_requests(300, 1'b0, 1'b1);
        test_random_requests(300, 1'b1, 1'b0);
        test_noise(500);
        test_drain_between_requests();

        // let the pipeline empty out
        wait_results();
        repeat (10) @(posedge clk);
        if (colour_results_q.size() != 0) begin
            $display("%0d expected results never arrived", colour_results_q.size());
            mismatches++;
        end

        $display("summary: %0d bytes in %0d requests sent", beats_sent, requests_sent);
        $display("summary: %0d colour updates, %0d bad requests, %0d mismatches",
                 changed_seen, bad_seen, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("timeout after %0t", $realtime);
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
